// ===== hw/rtl/lru_key_value_cache_macros.svh =====
// Assertion macros used by the checker file of the cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define LKC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lkc assertion failed");

// Concurrent check on clk_i that also holds across reset.
`define LKC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lkc reset assertion failed");

`endif

// ===== hw/rtl/lkc_pkg.sv =====
// Shared constants and types of the LRU key-value cache.
package lkc_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned DataW          = 32;
  localparam int unsigned CapW           = 5;
  localparam logic [CapW-1:0] CapReset   = 5'd16;

  localparam logic ActGet = 1'b0;
  localparam logic ActSet = 1'b1;

  // What the back end has to do with one word.
  typedef enum logic [2:0] {
    OP_GET_HIT,
    OP_GET_MISS,
    OP_SET_HIT,
    OP_SET_EVICT,
    OP_SET_INSERT
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  key;
    logic [DataW-1:0]  value;
  } op_t;

endpackage

// ===== hw/rtl/lkc_req_if.sv =====
// Request channel: action, key and value with valid/ready.
interface lkc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [lkc_pkg::DataW-1:0] key;
  logic signed [lkc_pkg::DataW-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink (input valid, action, key, value, output ready);
endinterface

// ===== hw/rtl/lkc_rsp_if.sv =====
// Response channel: found flag and read value with valid/ready.
interface lkc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic signed [lkc_pkg::DataW-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink (input valid, found, read_value, output ready);
endinterface

// ===== hw/rtl/lkc_queue.sv =====
// Short FIFO of classified operations between front and back end.
module lkc_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = lkc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             full;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full    = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= bump(wr_q);
      if (do_pop)  rd_q <= bump(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= wdata_i;
  end

endmodule

// ===== hw/rtl/lkc_front.sv =====
// Front end: takes request words, holds capacity, compares keys and classifies.
module lkc_front #(
  parameter int unsigned ENTRIES = lkc_pkg::DefaultEntries,
  parameter int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int unsigned OccW    = $clog2(ENTRIES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkc_pkg::CapW-1:0]  cfg_wdata_i,
  lkc_req_if.sink                   req_i,
  input  logic [lkc_pkg::DataW-1:0] key_i [ENTRIES],
  input  logic [ENTRIES-1:0]        valid_i,
  input  logic [IdxW-1:0]           rank_i [ENTRIES],
  input  logic [OccW-1:0]           occ_i,
  input  logic                      q_empty_i,
  output logic                      push_o,
  output lkc_pkg::op_t              op_o,
  output logic [IdxW-1:0]           slot_o,
  output logic [IdxW-1:0]           rank_o
);

  localparam int unsigned CW = (OccW > lkc_pkg::CapW) ? OccW : lkc_pkg::CapW;

  logic                      hold_q;
  logic                      act_q;
  logic [lkc_pkg::DataW-1:0] key_q, value_q;
  logic [lkc_pkg::CapW-1:0]  cap_q;

  logic                      classify;
  logic [ENTRIES-1:0]        match, lru, free;
  logic [IdxW-1:0]           hit_slot, lru_slot, free_slot, hit_rank, lru_rank;
  logic [CW-1:0]             cap_ext, eff_cap;
  logic                      full;

  // Classify only once every earlier op has updated the tags.
  assign classify    = hold_q && q_empty_i;
  assign req_i.ready = !hold_q || classify;
  assign push_o      = classify;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      cap_q  <= lkc_pkg::CapReset;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        hold_q <= 1'b1;
      end else if (classify) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q   <= req_i.action;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
  end

  assign lru_rank = IdxW'(occ_i - OccW'(1));

  always_comb begin
    match    = '0;
    lru      = '0;
    free     = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (key_i[i] == key_q);
      lru[i]   = valid_i[i] && (rank_i[i] == lru_rank);
      free[i]  = !valid_i[i];
      hit_rank = hit_rank | (match[i] ? rank_i[i] : '0);
    end
  end

  // Lowest index wins.
  always_comb begin
    hit_slot  = '0;
    lru_slot  = '0;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) hit_slot  = IdxW'(i);
      if (lru[i])   lru_slot  = IdxW'(i);
      if (free[i])  free_slot = IdxW'(i);
    end
  end

  // Capacity clamped to 1..ENTRIES.
  assign cap_ext = CW'(cap_q);
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CW'(occ_i) >= eff_cap);

  always_comb begin
    op_o.key   = key_q;
    op_o.value = value_q;
    slot_o     = hit_slot;
    rank_o     = hit_rank;
    priority if (act_q == lkc_pkg::ActGet) begin
      op_o.kind = (|match) ? lkc_pkg::OP_GET_HIT : lkc_pkg::OP_GET_MISS;
    end else if (|match) begin
      op_o.kind = lkc_pkg::OP_SET_HIT;
    end else if (full) begin
      op_o.kind = lkc_pkg::OP_SET_EVICT;
      slot_o    = lru_slot;
      rank_o    = lru_rank;
    end else begin
      op_o.kind = lkc_pkg::OP_SET_INSERT;
      slot_o    = free_slot;
      rank_o    = '0;
    end
  end

endmodule

// ===== hw/rtl/lkc_back.sv =====
// Back end: tag, recency and value storage, op execution and response register.
module lkc_back #(
  parameter int unsigned ENTRIES = lkc_pkg::DefaultEntries,
  parameter int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int unsigned OccW    = $clog2(ENTRIES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  lkc_pkg::op_t              op_i,
  input  logic [IdxW-1:0]           slot_i,
  input  logic [IdxW-1:0]           rank_i,
  output logic                      pop_o,
  output logic [lkc_pkg::DataW-1:0] key_o [ENTRIES],
  output logic [ENTRIES-1:0]        valid_o,
  output logic [IdxW-1:0]           rank_o [ENTRIES],
  output logic [OccW-1:0]           occ_o,
  lkc_rsp_if.source                 rsp_o
);

  logic [lkc_pkg::DataW-1:0] key_q [ENTRIES];
  logic [IdxW-1:0]           rank_q [ENTRIES];
  logic [ENTRIES-1:0]        valid_q;
  logic [OccW-1:0]           occ_q;
  logic [lkc_pkg::DataW-1:0] val_mem [ENTRIES];
  logic [lkc_pkg::DataW-1:0] rdata_q;

  logic                      resp_pend_q;
  lkc_pkg::kind_e            resp_kind_q;
  logic                      out_valid_q, out_found_q;
  logic [lkc_pkg::DataW-1:0] out_value_q;

  logic                      resp_move;
  logic                      is_set, is_alloc, is_touch, is_insert;
  logic                      resp_found;
  logic [lkc_pkg::DataW-1:0] resp_value;

  assign key_o   = key_q;
  assign rank_o  = rank_q;
  assign valid_o = valid_q;
  assign occ_o   = occ_q;

  assign resp_move = resp_pend_q && (!out_valid_q || rsp_o.ready);
  assign pop_o     = !q_empty_i && (!resp_pend_q || resp_move);

  assign is_insert = (op_i.kind == lkc_pkg::OP_SET_INSERT);
  assign is_alloc  = is_insert || (op_i.kind == lkc_pkg::OP_SET_EVICT);
  assign is_set    = is_alloc || (op_i.kind == lkc_pkg::OP_SET_HIT);
  assign is_touch  = (op_i.kind == lkc_pkg::OP_GET_HIT) || (op_i.kind == lkc_pkg::OP_SET_HIT)
                     || (op_i.kind == lkc_pkg::OP_SET_EVICT);

  // Recency: touched slot goes to rank 0, more recent valid slots age by one; an insert ages every valid slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (pop_o && is_insert) begin
      valid_q[slot_i] <= 1'b1;
      occ_q           <= occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_touch || is_insert) begin
          if (IdxW'(i) == slot_i) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (is_insert || rank_q[i] < rank_i)) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        if (is_alloc && IdxW'(i) == slot_i) key_q[i] <= op_i.key;
      end
    end
  end

  // Value memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rdata_q <= val_mem[slot_i];
      if (is_set) val_mem[slot_i] <= op_i.value;
    end
  end

  always_comb begin
    unique case (resp_kind_q)
      lkc_pkg::OP_GET_HIT: begin
        resp_found = 1'b1;
        resp_value = rdata_q;
      end
      lkc_pkg::OP_GET_MISS: begin
        resp_found = 1'b0;
        resp_value = '1;
      end
      lkc_pkg::OP_SET_HIT: begin
        resp_found = 1'b1;
        resp_value = '0;
      end
      default: begin
        resp_found = 1'b0;
        resp_value = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_pend_q <= 1'b0;
      resp_kind_q <= lkc_pkg::OP_GET_MISS;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        resp_pend_q <= 1'b1;
        resp_kind_q <= op_i.kind;
      end else if (resp_move) begin
        resp_pend_q <= 1'b0;
      end
      if (resp_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_move) begin
      out_found_q <= resp_found;
      out_value_q <= resp_value;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_value_q;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// Path from request accept to response valid: request register, queue, value read and
// response pending registers, output register. A word is classified only after the previous
// word has updated tags and recency (compare step, then update step).
// Reset: valid bits, occupancy and control clear at once; capacity resets to 16.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES     = lkc_pkg::DefaultEntries,
  parameter int unsigned QUEUE_DEPTH = lkc_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lkc_pkg::CapW-1:0] cfg_wdata_i,
  lkc_req_if.sink                  req_i,
  lkc_rsp_if.source                rsp_o
);

  // Slot index and recency rank share one width; occupancy can reach ENTRIES.
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned QW   = $bits(lkc_pkg::op_t) + 2 * IdxW;

  // Tag state owned by the back end, seen by the front end's comparators.
  logic [lkc_pkg::DataW-1:0] tag_key [ENTRIES];
  logic [IdxW-1:0]           tag_rank [ENTRIES];
  logic [ENTRIES-1:0]        tag_valid;
  logic [OccW-1:0]           occ;

  // Classified op on its way from front to back.
  lkc_pkg::op_t    f_op, b_op;
  logic [IdxW-1:0] f_slot, f_rank, b_slot, b_rank;
  logic            push, pop, q_empty;

  // Front: request register, capacity register, parallel key compare,
  // LRU / free slot search and hit/evict/insert decision.
  lkc_front #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW),
    .OccW    (OccW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .key_i       (tag_key),
    .valid_i     (tag_valid),
    .rank_i      (tag_rank),
    .occ_i       (occ),
    .q_empty_i   (q_empty),
    .push_o      (push),
    .op_o        (f_op),
    .slot_o      (f_slot),
    .rank_o      (f_rank)
  );

  // Queue decouples classification from execution; a stalled response
  // holds the op here while the front end keeps its next word.
  lkc_queue #(
    .Width (QW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_op, f_slot, f_rank}),
    .pop_i   (pop),
    .rdata_o ({b_op, b_slot, b_rank}),
    .empty_o (q_empty)
  );

  // Back: recency update, key/value writes, value read and output register.
  lkc_back #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW),
    .OccW    (OccW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .op_i      (b_op),
    .slot_i    (b_slot),
    .rank_i    (b_rank),
    .pop_o     (pop),
    .key_o     (tag_key),
    .valid_o   (tag_valid),
    .rank_o    (tag_rank),
    .occ_o     (occ),
    .rsp_o     (rsp_o)
  );

endmodule

// ===== hw/rtl/lkc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "lru_key_value_cache_macros.svh"

module lkc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_found_i,
  input logic [lkc_pkg::DataW-1:0] rsp_read_value_i
);

  // Words accepted but not yet delivered.
  logic [2:0] outst_q;
  logic       acc_in, acc_out;

  assign acc_in  = req_valid_i && req_ready_i;
  assign acc_out = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (acc_in && !acc_out) begin
      outst_q <= outst_q + 1'b1;
    end else if (acc_out && !acc_in) begin
      outst_q <= outst_q - 1'b1;
    end
  end

  `LKC_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_found_i) && $stable(rsp_read_value_i))
  `LKC_ASSERT(a_no_orphan_rsp, rsp_valid_i |-> outst_q != 3'd0)
  `LKC_ASSERT(a_outst_bound, outst_q <= 3'd4)
  `LKC_ASSERT(a_miss_value, rsp_valid_i && !rsp_found_i |-> rsp_read_value_i == '1 || rsp_read_value_i == '0)
  `LKC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !rsp_valid_i)

endmodule

bind lru_key_value_cache lkc_checker u_lkc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_found_i      (rsp_o.found),
  .rsp_read_value_i (rsp_o.read_value)
);
